// File: rtl/sfd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types, register codes and defaults of the stereo feedback delay.
// ----------------------------------------------------------------------------
package sfd_pkg;

	localparam int MAX_DELAY_DEF   = 32768;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int GAIN_W     = 16;
	localparam int CFG_W      = 16;
	localparam int REG_ADDR_W = 3;
	localparam int Q_SHIFT    = 15;

	localparam logic [REG_ADDR_W-1:0] REG_DRY_GAIN  = 3'd0;
	localparam logic [REG_ADDR_W-1:0] REG_WET_GAIN  = 3'd1;
	localparam logic [REG_ADDR_W-1:0] REG_LEFT_FB   = 3'd2;
	localparam logic [REG_ADDR_W-1:0] REG_RIGHT_FB  = 3'd3;
	localparam logic [REG_ADDR_W-1:0] REG_LEFT_LEN  = 3'd4;
	localparam logic [REG_ADDR_W-1:0] REG_RIGHT_LEN = 3'd5;

	localparam logic signed [GAIN_W-1:0] DRY_GAIN_RST = 16'sh7FFF;
	localparam logic signed [GAIN_W-1:0] GAIN_ZERO    = 16'sh0000;

	typedef struct packed {
		logic accept;   // request taken into stage 1
		logic adv_s1;   // stage 1 moves to stage 2 and writes the line
		logic len_wr;   // length register of this lane written
	} lane_ctrl_t;

endpackage
`default_nettype wire

// File: rtl/sfd_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_cfg
// Configuration register file: gains and clamped delay lengths.
// ----------------------------------------------------------------------------
module sfd_cfg import sfd_pkg::*; #(
	parameter int MAX_DELAY = MAX_DELAY_DEF,
	parameter int LEN_W     = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_valid,
	input  wire logic [REG_ADDR_W-1:0]    cfg_addr,
	input  wire logic [CFG_W-1:0]         cfg_data,
	output logic signed [GAIN_W-1:0]      dry_gain,
	output logic signed [GAIN_W-1:0]      wet_gain,
	output logic signed [GAIN_W-1:0]      left_fb,
	output logic signed [GAIN_W-1:0]      right_fb,
	output logic [LEN_W-1:0]              left_len,
	output logic [LEN_W-1:0]              right_len,
	output logic [LEN_W-1:0]              len_wdata,
	output logic                          left_len_wr,
	output logic                          right_len_wr
);

	localparam int CW = (LEN_W > CFG_W) ? LEN_W : CFG_W;
	localparam logic [CW-1:0] LEN_MAX = CW'(MAX_DELAY);
	localparam logic [CW-1:0] LEN_MIN = CW'(1);

	logic [CW-1:0] len_raw;
	logic [CW-1:0] len_clamped;

	// zero means one, anything above the line size means the full line
	always_comb begin
		len_raw = CW'(cfg_data);
		if (len_raw < LEN_MIN) begin
			len_clamped = LEN_MIN;
		end else if (len_raw > LEN_MAX) begin
			len_clamped = LEN_MAX;
		end else begin
			len_clamped = len_raw;
		end
	end

	assign len_wdata    = len_clamped[LEN_W-1:0];
	assign left_len_wr  = cfg_valid && (cfg_addr == REG_LEFT_LEN);
	assign right_len_wr = cfg_valid && (cfg_addr == REG_RIGHT_LEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dry_gain  <= DRY_GAIN_RST;
			wet_gain  <= GAIN_ZERO;
			left_fb   <= GAIN_ZERO;
			right_fb  <= GAIN_ZERO;
			left_len  <= LEN_W'(1);
			right_len <= LEN_W'(1);
		end else if (cfg_valid) begin
			case (cfg_addr)
				REG_DRY_GAIN:  dry_gain  <= $signed(cfg_data);
				REG_WET_GAIN:  wet_gain  <= $signed(cfg_data);
				REG_LEFT_FB:   left_fb   <= $signed(cfg_data);
				REG_RIGHT_FB:  right_fb  <= $signed(cfg_data);
				REG_LEFT_LEN:  left_len  <= len_wdata;
				REG_RIGHT_LEN: right_len <= len_wdata;
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/sfd_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_lane
// One channel: circular delay line, feedback write-back and wet/dry mix.
// ----------------------------------------------------------------------------
module sfd_lane import sfd_pkg::*; #(
	parameter int MAX_DELAY   = MAX_DELAY_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int IDX_W       = $clog2(MAX_DELAY),
	parameter int LEN_W       = IDX_W + 1
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire lane_ctrl_t                    ctrl,
	input  wire logic [LEN_W-1:0]              len,
	input  wire logic [LEN_W-1:0]              len_wdata,
	input  wire logic signed [GAIN_W-1:0]      fb_gain,
	input  wire logic signed [GAIN_W-1:0]      dry_gain,
	input  wire logic signed [GAIN_W-1:0]      wet_gain,
	input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
	output logic signed [SAMPLE_BITS-1:0]      sample_out
);

	localparam int SB = SAMPLE_BITS;
	localparam int PW = GAIN_W + SB;   // product
	localparam int AW = PW + 1;        // product plus rounding
	localparam int MW = PW + 2;        // sum of two products plus rounding
	localparam int SW = SB + 3;        // pre-saturation value
	localparam logic signed [AW-1:0] RND_A = AW'(1 << (Q_SHIFT - 1));
	localparam logic signed [MW-1:0] RND_M = MW'(1 << (Q_SHIFT - 1));
	localparam logic signed [SW-1:0] S_MAX = SW'((64'sd1 <<< (SB - 1)) - 64'sd1);
	localparam logic signed [SW-1:0] S_MIN = -S_MAX - SW'(1);

	function automatic logic signed [SB-1:0] sat_f(input logic signed [SW-1:0] v);
		if (v > S_MAX) begin
			return SB'(S_MAX);
		end else if (v < S_MIN) begin
			return SB'(S_MIN);
		end
		return SB'(v);
	endfunction

	logic signed [SB-1:0] line_mem [MAX_DELAY];

	logic [IDX_W-1:0]     idx_q;
	logic [LEN_W-1:0]     fill_q;    // entries below this were written since cleared
	logic [LEN_W-1:0]     idx_inc;
	logic [IDX_W-1:0]     idx_nxt;

	logic signed [SB-1:0] in_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic signed [SB-1:0] rdata_s1;
	logic                 hit_s1;
	logic                 fwd_s1;

	logic signed [SB-1:0] wval_s2;
	logic signed [PW-1:0] dry_s2;
	logic signed [PW-1:0] wet_s2;

	logic signed [SB-1:0] rd;
	logic signed [PW-1:0] fb_prod;
	logic signed [AW-1:0] fb_acc;
	logic signed [SB-1:0] fb_q;
	logic signed [SB-1:0] wval;
	logic signed [MW-1:0] mix_acc;

	assign idx_inc = LEN_W'(idx_q) + LEN_W'(1);
	assign idx_nxt = (idx_inc >= len) ? '0 : idx_inc[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			fill_q <= '0;
		end else if (ctrl.len_wr) begin
			// entries at or above the new length count as cleared
			idx_q <= '0;
			if (len_wdata < fill_q) begin
				fill_q <= len_wdata;
			end
		end else if (ctrl.accept) begin
			idx_q <= idx_nxt;
			if (LEN_W'(idx_q) == fill_q) begin
				fill_q <= fill_q + LEN_W'(1);
			end
		end
	end

	// line memory: read on request, write back when stage 1 advances
	always_ff @(posedge clk) begin
		if (ctrl.adv_s1) begin
			line_mem[idx_s1] <= wval;
		end
		if (ctrl.accept) begin
			rdata_s1 <= line_mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			in_s1  <= sample_in;
			idx_s1 <= idx_q;
			hit_s1 <= (LEN_W'(idx_q) < fill_q);
			// the entry still being written by the request ahead misses memory
			fwd_s1 <= ctrl.adv_s1 && (idx_s1 == idx_q);
		end
	end

	always_comb begin
		if (fwd_s1) begin
			rd = wval_s2;
		end else if (hit_s1) begin
			rd = rdata_s1;
		end else begin
			rd = '0;
		end
	end

	assign fb_prod = PW'(fb_gain) * PW'(rd);
	assign fb_acc  = AW'(fb_prod) + RND_A;
	assign fb_q    = sat_f(SW'($signed(fb_acc[AW-1:Q_SHIFT])));
	assign wval    = sat_f(SW'(in_s1) + SW'(fb_q));

	always_ff @(posedge clk) begin
		if (ctrl.adv_s1) begin
			wval_s2 <= wval;
			dry_s2  <= PW'(dry_gain) * PW'(in_s1);
			wet_s2  <= PW'(wet_gain) * PW'(rd);
		end
	end

	assign mix_acc    = MW'(dry_s2) + MW'(wet_s2) + RND_M;
	assign sample_out = sat_f(SW'($signed(mix_acc[MW-1:Q_SHIFT])));

endmodule
`default_nettype wire

// File: rtl/stereo_feedback_delay.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_feedback_delay
// Stereo feedback delay with wet/dry mix, one sample pair per request.
// ----------------------------------------------------------------------------
// Usage:
//   s_tdata carries one stereo pair (left low, right high); m_tdata returns
//   the mixed pair in the same layout. Every input request gives exactly one
//   output request, in order.
//   The cfg channel writes gains and line lengths by register index; it is
//   always ready and must only be used while no request is in flight.
//   m_tvalid rises once the pair has passed stage 1, stage 2 and the output
//   register. Throughput is one pair per cycle while the output is not
//   stalled, as the read-modify-write of each lane's line memory allows
//   (read on request, write when stage 1 advances, with forwarding of the
//   entry still being written).
//   When m_tready is low the result holds in the output register while the
//   two inner stages keep filling; up to three pairs are held before
//   s_tready drops.
//   Reset clears the config and valid registers, indexes and the
//   written-entry marks of both lines; no clearing pass runs, so the block
//   takes requests in the first cycle after reset. Entries not written
//   since reset or since a shorter length was set read as zero.
// ----------------------------------------------------------------------------
module stereo_feedback_delay import sfd_pkg::*; #(
	parameter int MAX_DELAY   = MAX_DELAY_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	localparam int DW = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [DW-1:0]         s_tdata,   // left_in, right_in, zero pad
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [DW-1:0]              m_tdata,   // left_out, right_out, zero pad
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [REG_ADDR_W-1:0] cfg_addr,
	input  wire logic [CFG_W-1:0]      cfg_data
);

	localparam int SB    = SAMPLE_BITS;
	localparam int IDX_W = $clog2(MAX_DELAY);
	localparam int LEN_W = IDX_W + 1;

	logic signed [GAIN_W-1:0] dry_gain;
	logic signed [GAIN_W-1:0] wet_gain;
	logic signed [GAIN_W-1:0] left_fb;
	logic signed [GAIN_W-1:0] right_fb;
	logic [LEN_W-1:0]         left_len;
	logic [LEN_W-1:0]         right_len;
	logic [LEN_W-1:0]         len_wdata;
	logic                     left_len_wr;
	logic                     right_len_wr;

	logic       v1_q;
	logic       v2_q;
	logic       out_valid_q;
	logic       out_free;
	logic       adv1;
	logic       adv2;
	logic       accept;
	lane_ctrl_t left_ctrl;
	lane_ctrl_t right_ctrl;

	logic signed [SB-1:0] left_mix;
	logic signed [SB-1:0] right_mix;
	logic signed [SB-1:0] left_out_q;
	logic signed [SB-1:0] right_out_q;

	assign cfg_ready = 1'b1;

	sfd_cfg #(
		.MAX_DELAY(MAX_DELAY),
		.LEN_W    (LEN_W)
	) u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_addr    (cfg_addr),
		.cfg_data    (cfg_data),
		.dry_gain    (dry_gain),
		.wet_gain    (wet_gain),
		.left_fb     (left_fb),
		.right_fb    (right_fb),
		.left_len    (left_len),
		.right_len   (right_len),
		.len_wdata   (len_wdata),
		.left_len_wr (left_len_wr),
		.right_len_wr(right_len_wr)
	);

	// stages move independently so bubbles collapse under a stalled output
	assign out_free = !out_valid_q || m_tready;
	assign adv2     = v2_q && out_free;
	assign adv1     = v1_q && (!v2_q || adv2);
	assign s_tready = !v1_q || adv1;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		left_ctrl.accept  = accept;
		left_ctrl.adv_s1  = adv1;
		left_ctrl.len_wr  = left_len_wr;
		right_ctrl.accept = accept;
		right_ctrl.adv_s1 = adv1;
		right_ctrl.len_wr = right_len_wr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				v1_q <= 1'b1;
			end else if (adv1) begin
				v1_q <= 1'b0;
			end
			if (adv1) begin
				v2_q <= 1'b1;
			end else if (adv2) begin
				v2_q <= 1'b0;
			end
			if (adv2) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	sfd_lane #(
		.MAX_DELAY  (MAX_DELAY),
		.SAMPLE_BITS(SAMPLE_BITS),
		.IDX_W      (IDX_W),
		.LEN_W      (LEN_W)
	) u_lane_left (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (left_ctrl),
		.len       (left_len),
		.len_wdata (len_wdata),
		.fb_gain   (left_fb),
		.dry_gain  (dry_gain),
		.wet_gain  (wet_gain),
		.sample_in ($signed(s_tdata[SB-1:0])),
		.sample_out(left_mix)
	);

	sfd_lane #(
		.MAX_DELAY  (MAX_DELAY),
		.SAMPLE_BITS(SAMPLE_BITS),
		.IDX_W      (IDX_W),
		.LEN_W      (LEN_W)
	) u_lane_right (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (right_ctrl),
		.len       (right_len),
		.len_wdata (len_wdata),
		.fb_gain   (right_fb),
		.dry_gain  (dry_gain),
		.wet_gain  (wet_gain),
		.sample_in ($signed(s_tdata[2*SB-1:SB])),
		.sample_out(right_mix)
	);

	// merge both lanes into one output request
	always_ff @(posedge clk) begin
		if (adv2) begin
			left_out_q  <= left_mix;
			right_out_q <= right_mix;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = DW'({right_out_q, left_out_q});

endmodule
`default_nettype wire

// File: rtl/sfd_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_chk
// Port-level checks of the stereo feedback delay, bound to the top level.
// ----------------------------------------------------------------------------
module sfd_chk import sfd_pkg::*; #(
	parameter int DW = 32
) (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          s_tvalid,
	input wire logic          s_tready,
	input wire logic          m_tvalid,
	input wire logic          m_tready,
	input wire logic [DW-1:0] m_tdata
);

	logic [2:0] inflight_q;
	logic       in_req;
	logic       out_req;

	assign in_req  = s_tvalid && s_tready;
	assign out_req = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_req && !out_req) begin
			inflight_q <= inflight_q + 3'd1;
		end else if (out_req && !in_req) begin
			inflight_q <= inflight_q - 3'd1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output request changed while stalled");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 3'd3)
		else $error("more than three requests in flight");

	a_full_only: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> inflight_q == 3'd3)
		else $error("input stalled with room left in the pipeline");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == 3'd0 |-> !m_tvalid)
		else $error("output request with nothing in flight");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_req && inflight_q == 3'd0 |-> ##3 m_tvalid)
		else $error("result missing three cycles after request into empty pipe");

endmodule

bind stereo_feedback_delay sfd_chk #(.DW(DW)) u_sfd_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
`default_nettype wire
